/* hw/rtl/itra_pkg.sv */
// Package for the radix ASCII converter: widths, character codes, the digit
// to ASCII function and the request, response and queue entry types used by
// the modules. No dependencies.
`timescale 1ns / 1ps

package itra_pkg;

  localparam int unsigned ValueBits  = 64;
  localparam int unsigned NumberW    = 64;
  localparam int unsigned MagW       = ValueBits - 1;
  localparam int unsigned BaseW      = 6;
  localparam int unsigned RemW       = BaseW + 1;
  localparam int unsigned CharW      = 7;
  localparam int unsigned DigitSlots = 64;
  localparam int unsigned IdxW       = 6;
  localparam int unsigned CntW       = 7;
  localparam int unsigned DivStep    = 8;
  localparam int unsigned DivPasses  = (MagW + DivStep - 1) / DivStep;
  localparam int unsigned DivW       = DivPasses * DivStep;
  localparam int unsigned PassW      = (DivPasses > 1) ? $clog2(DivPasses) : 1;

  localparam logic [BaseW-1:0] RadixMin   = BaseW'(2);
  localparam logic [BaseW-1:0] RadixMax   = BaseW'(36);
  localparam logic [BaseW-1:0] DecimalTen = BaseW'(10);

  localparam logic [CharW-1:0] AsciiZero   = 7'h30;
  localparam logic [CharW-1:0] AsciiLowerA = 7'h61;
  localparam logic [CharW-1:0] AsciiMinus  = 7'h2d;

  typedef struct packed {
    logic [NumberW-1:0] number;
    logic [BaseW-1:0]   base;
  } req_t;

  typedef struct packed {
    logic [CharW-1:0] character;
    logic             last;
  } rsp_t;

  typedef struct packed {
    logic [MagW-1:0]  mag;
    logic [BaseW-1:0] base;
    logic             neg;
  } item_t;

  function automatic logic [CharW-1:0] ascii_of(input logic [BaseW-1:0] d);
    logic [CharW-1:0] c;
    if (d < DecimalTen) begin
      c = AsciiZero + CharW'(d);
    end else begin
      c = AsciiLowerA + CharW'(d - DecimalTen);
    end
    return c;
  endfunction

endpackage

/* hw/rtl/itra_front.sv */
// Front end of the radix ASCII converter: takes requests, clamps the radix,
// splits the value into sign and saturated magnitude. Depends on itra_pkg.
`timescale 1ns / 1ps

module itra_front (
  input  logic          start,
  input  itra_pkg::req_t req_i,
  input  logic          full_i,
  output logic          busy,
  output logic          push_o,
  output itra_pkg::item_t item_o
);
  import itra_pkg::*;

  logic [ValueBits-1:0] raw;
  logic [ValueBits-1:0] neg_raw;
  logic [ValueBits-1:0] sign_bit;
  logic [ValueBits-1:0] mag_full;
  logic                 neg;

  assign busy     = full_i;
  assign push_o   = start && !full_i;
  assign raw      = req_i.number[ValueBits-1:0];
  assign neg      = raw[ValueBits-1];
  assign neg_raw  = ~raw + ValueBits'(1);
  assign sign_bit = {1'b1, {(ValueBits-1){1'b0}}};

  always_comb begin
    if (!neg) begin
      mag_full = raw;
    end else if (neg_raw == sign_bit) begin
      mag_full = sign_bit - ValueBits'(1);
    end else begin
      mag_full = neg_raw;
    end
  end

  always_comb begin
    item_o.mag = mag_full[MagW-1:0];
    item_o.neg = neg;
    if (req_i.base < RadixMin) begin
      item_o.base = RadixMin;
    end else if (req_i.base > RadixMax) begin
      item_o.base = RadixMax;
    end else begin
      item_o.base = req_i.base;
    end
  end

endmodule

/* hw/rtl/itra_queue.sv */
// Two-entry queue between the front end and the conversion engine of the
// radix ASCII converter. Depends on itra_pkg.
`timescale 1ns / 1ps

module itra_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  itra_pkg::item_t item_i,
  input  logic            pop_i,
  output logic            full_o,
  output logic            empty_o,
  output itra_pkg::item_t item_o
);
  import itra_pkg::*;

  item_t       slot_q [2];
  logic        wr_q, wr_d;
  logic        rd_q, rd_d;
  logic [1:0]  cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign item_o  = slot_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = !wr_q;
    end
    if (pop_i) begin
      rd_d = !rd_q;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= item_i;
    end
  end

endmodule

/* hw/rtl/itra_back.sv */
// Conversion engine of the radix ASCII converter: repeated division by the
// radix, eight quotient bits a cycle, digits kept in a local memory and sent
// out most significant first. Depends on itra_pkg.
`timescale 1ns / 1ps

module itra_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            empty_i,
  input  itra_pkg::item_t item_i,
  output logic            pop_o,
  output logic            valid_o,
  output itra_pkg::rsp_t  rsp_o
);
  import itra_pkg::*;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StDiv  = 3'd1;
  localparam logic [2:0] StSign = 3'd2;
  localparam logic [2:0] StRead = 3'd3;
  localparam logic [2:0] StOut  = 3'd4;

  logic [2:0]       state_q, state_d;
  logic [DivW-1:0]  div_q, div_d;
  logic [RemW-1:0]  rem_q, rem_d;
  logic [BaseW-1:0] base_q, base_d;
  logic             neg_q, neg_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [IdxW-1:0]  idx_q, idx_d;
  logic [PassW-1:0] pass_q, pass_d;
  logic             valid_q, valid_d;
  rsp_t             rsp_q, rsp_d;

  logic [BaseW-1:0] mem_q [DigitSlots];
  logic [BaseW-1:0] rd_q;
  logic             wr_en;
  logic [RemW-1:0]  rem_v;
  logic [DivW-1:0]  div_v;
  logic             last_pass;

  always_comb begin
    rem_v = rem_q;
    div_v = div_q;
    for (int i = 0; i < DivStep; i++) begin
      rem_v = {rem_v[RemW-2:0], div_v[DivW-1]};
      div_v = {div_v[DivW-2:0], 1'b0};
      if (rem_v >= {1'b0, base_q}) begin
        rem_v    = rem_v - {1'b0, base_q};
        div_v[0] = 1'b1;
      end
    end
  end

  assign last_pass = (pass_q == PassW'(DivPasses - 1));
  assign wr_en     = (state_q == StDiv) && last_pass;
  assign pop_o     = (state_q == StIdle) && !empty_i;
  assign valid_o   = valid_q;
  assign rsp_o     = rsp_q;

  always_comb begin
    state_d = state_q;
    div_d   = div_q;
    rem_d   = rem_q;
    base_d  = base_q;
    neg_d   = neg_q;
    cnt_d   = cnt_q;
    idx_d   = idx_q;
    pass_d  = pass_q;
    valid_d = 1'b0;
    rsp_d   = rsp_q;
    unique case (state_q)
      StIdle: begin
        if (!empty_i) begin
          div_d   = DivW'(item_i.mag);
          rem_d   = '0;
          base_d  = item_i.base;
          neg_d   = item_i.neg;
          cnt_d   = '0;
          pass_d  = '0;
          state_d = StDiv;
        end
      end
      StDiv: begin
        div_d  = div_v;
        rem_d  = rem_v;
        pass_d = pass_q + PassW'(1);
        if (last_pass) begin
          rem_d  = '0;
          pass_d = '0;
          cnt_d  = cnt_q + CntW'(1);
          if (div_v == '0 || cnt_q == CntW'(DigitSlots - 1)) begin
            idx_d   = cnt_q[IdxW-1:0];
            state_d = neg_q ? StSign : StRead;
          end
        end
      end
      StSign: begin
        valid_d         = 1'b1;
        rsp_d.character = AsciiMinus;
        rsp_d.last      = 1'b0;
        state_d         = StOut;
      end
      StRead: begin
        state_d = StOut;
      end
      StOut: begin
        valid_d         = 1'b1;
        rsp_d.character = ascii_of(rd_q);
        rsp_d.last      = (idx_q == '0);
        if (idx_q == '0) begin
          state_d = StIdle;
        end else begin
          idx_d   = idx_q - IdxW'(1);
          state_d = StRead;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
      idx_q   <= '0;
      pass_q  <= '0;
      neg_q   <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      pass_q  <= pass_d;
      neg_q   <= neg_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    div_q  <= div_d;
    rem_q  <= rem_d;
    base_q <= base_d;
    rsp_q  <= rsp_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[cnt_q[IdxW-1:0]] <= rem_v[BaseW-1:0];
    end
    rd_q <= mem_q[idx_q];
  end

endmodule

/* hw/rtl/integer_to_radix_ascii.sv */
// Signed integer to radix ASCII converter, top level. Depends on itra_pkg,
// itra_front, itra_queue and itra_back. The engine pops a request from the
// queue, runs the division passes for each digit, then reads and sends each
// digit in turn, the sign sharing its slot with the first digit. The engine
// takes a new request only after the last character of the previous one, the
// two-entry queue holds the next ones and results cannot be stalled.
// Reset is asynchronous and clears control state but not the digit memory.
`timescale 1ns / 1ps

module integer_to_radix_ascii (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  itra_pkg::req_t req_i,
  output logic           valid_o,
  output itra_pkg::rsp_t rsp_o
);
  import itra_pkg::*;

  logic  push;
  logic  pop;
  logic  full;
  logic  empty;
  item_t front_item;
  item_t queue_item;

  itra_front u_front (
    .start  (start),
    .req_i  (req_i),
    .full_i (full),
    .busy   (busy),
    .push_o (push),
    .item_o (front_item)
  );

  itra_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .pop_i   (pop),
    .full_o  (full),
    .empty_o (empty),
    .item_o  (queue_item)
  );

  itra_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .item_i  (queue_item),
    .pop_o   (pop),
    .valid_o (valid_o),
    .rsp_o   (rsp_o)
  );

endmodule

/* verif/testbench.sv */
// Self-checking testbench for integer_to_radix_ascii: drives conversion requests,
// predicts the character text of each one and compares every strobed character.
// Depends on itra_pkg and the integer_to_radix_ascii RTL.
`timescale 1ns / 1ps

module testbench;

  import itra_pkg::*;

  localparam int unsigned StallLimit  = 4000;
  localparam int unsigned DrainCycles = 700;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  req_t req_i;
  logic valid_o;
  rsp_t rsp_o;

  rsp_t expected_chars[$];
  int   mismatch_count;
  int   requests_sent;
  int   negatives_sent;
  int   chars_checked;
  int   stall_cycles;

  integer_to_radix_ascii i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .req_i   (req_i),
    .valid_o (valid_o),
    .rsp_o   (rsp_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Appends the characters that one request is expected to produce.
  function automatic void predict_text(input req_t r);
    logic [63:0] value_mask;
    logic [63:0] sign_bit;
    logic [63:0] raw;
    logic [63:0] magnitude;
    logic [63:0] radix;
    logic [5:0]  digits[64];
    logic [5:0]  d;
    int          num_digits;
    bit          is_negative;
    rsp_t        c;
    value_mask = (ValueBits >= 64) ? '1 : ((64'd1 << ValueBits) - 64'd1);
    sign_bit   = 64'd1 << (ValueBits - 1);
    raw        = r.number & value_mask;
    radix      = 64'(r.base);
    if (radix < 64'(RadixMin)) begin
      radix = 64'(RadixMin);
    end
    if (radix > 64'(RadixMax)) begin
      radix = 64'(RadixMax);
    end
    is_negative = (raw & sign_bit) != 0;
    if (is_negative) begin
      magnitude = (~raw + 64'd1) & value_mask;
      if (magnitude == sign_bit) begin
        magnitude = sign_bit - 64'd1;
      end
    end else begin
      magnitude = raw;
    end
    magnitude  = magnitude & 64'h7fff_ffff_ffff_ffff;
    num_digits = 0;
    do begin
      digits[num_digits] = 6'(magnitude % radix);
      magnitude          = magnitude / radix;
      num_digits++;
    end while (magnitude != 0 && num_digits < DigitSlots);
    if (is_negative) begin
      c.character = AsciiMinus;
      c.last      = 1'b0;
      expected_chars.push_back(c);
      negatives_sent++;
    end
    for (int k = num_digits - 1; k >= 0; k--) begin
      d = digits[k];
      if (d < 6'd10) begin
        c.character = AsciiZero + CharW'(d);
      end else begin
        c.character = AsciiLowerA + CharW'(d - 6'd10);
      end
      c.last = (k == 0);
      expected_chars.push_back(c);
    end
  endfunction

  task automatic send_request(input logic [63:0] num, input logic [5:0] b, input bit with_idle);
    req_t r;
    r.number = num;
    r.base   = b;
    if (with_idle && $urandom_range(0, 2) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    predict_text(r);
    requests_sent++;
  endtask

  task automatic wait_for_drain();
    start <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_value_extremes();
    send_request(64'd0, 6'd10, 1'b1);
    send_request(64'd0, 6'd2, 1'b1);
    send_request(64'd1, 6'd10, 1'b1);
    send_request(-64'sd1, 6'd10, 1'b1);
    send_request(64'h7fff_ffff_ffff_ffff, 6'd2, 1'b1);
    send_request(64'h7fff_ffff_ffff_ffff, 6'd36, 1'b1);
    send_request(64'h8000_0000_0000_0000, 6'd2, 1'b1);
    send_request(64'h8000_0000_0000_0000, 6'd10, 1'b1);
    send_request(64'h8000_0000_0000_0001, 6'd16, 1'b1);
    send_request(64'hffff_ffff_ffff_ffff, 6'd36, 1'b1);
  endtask

  task automatic test_radix_clamp();
    send_request(64'd255, 6'd0, 1'b1);
    send_request(64'd255, 6'd1, 1'b1);
    send_request(-64'sd255, 6'd37, 1'b1);
    send_request(64'd1295, 6'd63, 1'b1);
  endtask

  task automatic test_digit_letters();
    send_request(64'd35, 6'd36, 1'b1);
    send_request(64'd36, 6'd36, 1'b1);
    send_request(64'd255, 6'd16, 1'b1);
    send_request(-64'sd255, 6'd16, 1'b1);
    send_request(64'd1234567890, 6'd10, 1'b1);
    send_request(64'd9, 6'd10, 1'b1);
    send_request(64'd7, 6'd8, 1'b1);
  endtask

  task automatic test_random_requests(input int count, input bit with_idle);
    logic [63:0] num;
    logic [5:0]  b;
    int          w;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        num = {$urandom(), $urandom()};
      end else begin
        w   = $urandom_range(1, 63);
        num = {$urandom(), $urandom()} & ((64'd1 << w) - 64'd1);
        if ($urandom_range(0, 1) == 1) begin
          num = -num;
        end
      end
      if ($urandom_range(0, 6) == 0) begin
        b = 6'($urandom_range(0, 63));
      end else begin
        b = 6'($urandom_range(2, 36));
      end
      send_request(num, b, with_idle);
    end
  endtask

  task automatic test_drain_pause();
    test_random_requests(5, 1'b1);
    wait_for_drain();
    test_random_requests(5, 1'b1);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && valid_o) begin
      if (expected_chars.size() == 0) begin
        $display("%0t: unexpected character: expected none, actual %h last %b",
                 $time, rsp_o.character, rsp_o.last);
        mismatch_count++;
      end else begin
        if (rsp_o.character !== expected_chars[0].character) begin
          $display("%0t: character mismatch: expected %h, actual %h",
                   $time, expected_chars[0].character, rsp_o.character);
          mismatch_count++;
        end
        if (rsp_o.last !== expected_chars[0].last) begin
          $display("%0t: last flag mismatch: expected %b, actual %b",
                   $time, expected_chars[0].last, rsp_o.last);
          mismatch_count++;
        end
        void'(expected_chars.pop_front());
        chars_checked++;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || valid_o) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("%0t: no progress for %0d cycles", $time, StallLimit);
      $display("tb: failure");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst_ni         = 1'b0;
    start          = 1'b0;
    req_i          = '0;
    mismatch_count = 0;
    requests_sent  = 0;
    negatives_sent = 0;
    chars_checked  = 0;
    stall_cycles   = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_value_extremes();
    test_radix_clamp();
    test_digit_letters();
    test_drain_pause();
    test_random_requests(130, 1'b1);
    test_random_requests(50, 1'b0);

    wait_for_drain();
    repeat (DrainCycles) @(posedge clk_i);

    $display("Converted %0d requests (%0d negative) into %0d checked characters,",
             requests_sent, negatives_sent, chars_checked);
    $display("covering value extremes, radix clamping, letter digits and random traffic.");
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/itra_pkg.sv
hw/rtl/itra_front.sv
hw/rtl/itra_queue.sv
hw/rtl/itra_back.sv
hw/rtl/integer_to_radix_ascii.sv
verif/testbench.sv
